### design/edq_pkg.sv
// Package for the EDF deadline queue: sizes, opcodes, status codes, the
// request/response beat structs and the controller->datapath command struct. No dependencies.
`default_nettype none
package edq_pkg;
    localparam int CAPACITY = 16;
    localparam int ID_BITS  = 16;
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);

    localparam logic [2:0] OP_ASSIGN = 3'd0;
    localparam logic [2:0] OP_UPDATE = 3'd1;
    localparam logic [2:0] OP_ADD    = 3'd2;
    localparam logic [2:0] OP_REMOVE = 3'd3;
    localparam logic [2:0] OP_PEEK   = 3'd4;
    localparam logic [2:0] OP_SELECT = 3'd5;
    localparam logic [2:0] OP_CLEAR  = 3'd6;
    localparam logic [2:0] OP_NOP    = 3'd7;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_BAD_ID    = 3'd1;
    localparam logic [2:0] ST_QUEUED    = 3'd2;
    localparam logic [2:0] ST_FULL      = 3'd3;
    localparam logic [2:0] ST_NOT_FOUND = 3'd4;

    typedef struct packed {
        logic [2:0]  opcode;
        logic [15:0] task_id;
        logic [31:0] deadline;
        logic [31:0] cur_tick;
    } req_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [15:0] task_out;
        logic        ready_res;
        logic [4:0]  queue_len;
    } rsp_t;

    // controller -> datapath
    typedef struct packed {
        logic load;     // capture request
        logic lookup;   // register search results
        logic exec;     // apply operation
    } cmd_t;
endpackage
`default_nettype wire

### design/edq_if.sv
// Valid/ready channel interface carrying a payload of type T.
// Depends on nothing.
`default_nettype none
interface edq_if #(parameter type T = logic) (input wire logic clk);
    logic valid;
    logic ready;
    T     data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

### design/edf_deadline_queue_unit.sv
// Top level of the EDF deadline queue: controller plus datapath.
// Depends on edq_pkg, edq_if, edq_ctrl, edq_datapath.
//
//  channel | dir | beat payload
//  req     | in  | opcode, task_id, deadline, cur_tick
//  rsp     | out | status, task_out, ready_res, queue_len
//
// One beat at a time, in order: accept (load), lookup
// of registry and queue by parallel compare, exec with queue shift, output.
// Result is valid after the LOOK and EXEC states and held until taken;
// the next request beat is accepted the cycle after the result is taken.
// Reset clears registry valid bits and queue count; no clearing pass.
`default_nettype none
module edf_deadline_queue_unit (
    input  wire logic clk,
    input  wire logic rst_n,
    edq_if.sink       req,
    edq_if.source     rsp
);
    edq_pkg::cmd_t cmd;
    edq_pkg::rsp_t dp_rsp;

    edq_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n),
        .in_valid(req.valid), .in_ready(req.ready),
        .out_valid(rsp.valid), .out_ready(rsp.ready),
        .cmd(cmd)
    );

    edq_datapath u_dp (
        .clk(clk), .rst_n(rst_n),
        .cmd(cmd), .req(req.data), .rsp(dp_rsp)
    );

    assign rsp.data = dp_rsp;
endmodule
`default_nettype wire

### design/edq_datapath.sv
// Datapath: registry, sorted ready queue, parallel search and shift.
// Depends on edq_pkg.
`default_nettype none
module edq_datapath (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire edq_pkg::cmd_t cmd,
    input  wire edq_pkg::req_t req,
    output edq_pkg::rsp_t      rsp
);
    localparam int N = edq_pkg::CAPACITY;
    localparam int IW = edq_pkg::IDX_W;
    localparam int CW = edq_pkg::CNT_W;

    // a strictly later than b, modulo 2^32
    function automatic logic is_later(input logic [31:0] a, input logic [31:0] b);
        logic [31:0] d;
        d = a - b;
        return (d != 32'd0) && !d[31];
    endfunction

    edq_pkg::req_t req_reg;
    logic [N-1:0]  reg_valid_reg;
    logic [edq_pkg::ID_BITS-1:0] reg_task_reg [N];
    logic [31:0]   reg_rel_reg [N];
    logic [edq_pkg::ID_BITS-1:0] q_task_reg [N];
    logic [31:0]   q_abs_reg [N];
    logic [CW-1:0] count_reg;
    logic [2:0]    status_reg;
    logic [15:0]   tout_reg;

    logic [edq_pkg::ID_BITS-1:0] id;
    assign id = req_reg.task_id[edq_pkg::ID_BITS-1:0];

    // lookup stage results
    logic          rhit_reg, qhit_reg, free_reg;
    logic [IW-1:0] rpos_reg, qpos_reg, fpos_reg;
    logic [31:0]   abs_reg;
    logic          rhit, qhit, free;
    logic [IW-1:0] rpos, qpos, fpos;
    logic [N-1:0]  later;
    logic [CW-1:0] ipos;

    always_comb
    begin
        rhit = 1'b0; qhit = 1'b0; free = 1'b0;
        rpos = '0; qpos = '0; fpos = '0;
        for (int i = N - 1; i >= 0; i--)
        begin
            if (reg_valid_reg[i] && reg_task_reg[i] == id)
            begin
                rhit = 1'b1; rpos = IW'(i);
            end
            if (CW'(i) < count_reg && q_task_reg[i] == id)
            begin
                qhit = 1'b1; qpos = IW'(i);
            end
            if (!reg_valid_reg[i])
            begin
                free = 1'b1; fpos = IW'(i);
            end
        end
    end

    // insertion point from the registered absolute deadline: first later entry
    always_comb
    begin
        for (int i = 0; i < N; i++)
            later[i] = (CW'(i) < count_reg) && is_later(q_abs_reg[i], abs_reg);
        ipos = count_reg;
        for (int i = N - 1; i >= 0; i--)
            if (later[i])
                ipos = CW'(i);
    end

    // operation decode for the exec cycle
    logic [2:0]  st;
    logic [15:0] tout;
    logic        reg_upd, reg_new, q_ins, q_del, q_pop, q_clr;

    always_comb
    begin
        st      = edq_pkg::ST_OK;
        tout    = 16'd0;
        reg_upd = 1'b0;
        reg_new = 1'b0;
        q_ins   = 1'b0;
        q_del   = 1'b0;
        q_pop   = 1'b0;
        q_clr   = 1'b0;
        if (req_reg.opcode <= edq_pkg::OP_REMOVE && id == '0)
            st = edq_pkg::ST_BAD_ID;
        else
        begin
            unique case (req_reg.opcode)
                edq_pkg::OP_ASSIGN, edq_pkg::OP_UPDATE:
                begin
                    if (rhit_reg)
                        reg_upd = 1'b1;
                    else if (req_reg.opcode == edq_pkg::OP_UPDATE)
                        st = edq_pkg::ST_NOT_FOUND;
                    else if (!free_reg)
                        st = edq_pkg::ST_FULL;
                    else
                        reg_new = 1'b1;
                end
                edq_pkg::OP_ADD:
                begin
                    if (count_reg >= CW'(N))
                        st = edq_pkg::ST_FULL;
                    else if (qhit_reg)
                        st = edq_pkg::ST_QUEUED;
                    else if (!rhit_reg)
                        st = edq_pkg::ST_NOT_FOUND;
                    else
                        q_ins = 1'b1;
                end
                edq_pkg::OP_REMOVE:
                begin
                    if (!qhit_reg)
                        st = edq_pkg::ST_NOT_FOUND;
                    else
                        q_del = 1'b1;
                end
                edq_pkg::OP_PEEK, edq_pkg::OP_SELECT:
                begin
                    if (count_reg == '0)
                        st = edq_pkg::ST_NOT_FOUND;
                    else
                    begin
                        tout  = 16'(q_task_reg[0]);
                        q_pop = (req_reg.opcode == edq_pkg::OP_SELECT);
                    end
                end
                edq_pkg::OP_CLEAR:
                    q_clr = 1'b1;
                default:
                    st = edq_pkg::ST_OK;
            endcase
        end
    end

    // control state with reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            reg_valid_reg <= '0;
            count_reg     <= '0;
            status_reg    <= edq_pkg::ST_OK;
            tout_reg      <= 16'd0;
        end
        else if (cmd.exec)
        begin
            if (reg_new)
                reg_valid_reg[fpos_reg] <= 1'b1;
            if (q_ins)
                count_reg <= count_reg + CW'(1);
            else if (q_del || q_pop)
                count_reg <= count_reg - CW'(1);
            else if (q_clr)
                count_reg <= '0;
            status_reg <= st;
            tout_reg   <= tout;
        end
    end

    // request, lookup results and storage arrays; no reset needed
    always_ff @(posedge clk)
    begin
        if (cmd.load)
            req_reg <= req;
        if (cmd.lookup)
        begin
            rhit_reg <= rhit; qhit_reg <= qhit; free_reg <= free;
            rpos_reg <= rpos; qpos_reg <= qpos; fpos_reg <= fpos;
            abs_reg  <= req_reg.cur_tick + reg_rel_reg[rpos];
        end
        if (cmd.exec)
        begin
            if (reg_upd)
                reg_rel_reg[rpos_reg] <= req_reg.deadline;
            if (reg_new)
            begin
                reg_task_reg[fpos_reg] <= id;
                reg_rel_reg[fpos_reg]  <= req_reg.deadline;
            end
            if (q_ins)
            begin
                for (int i = 1; i < N; i++)
                    if (CW'(i) > ipos)
                    begin
                        q_task_reg[i] <= q_task_reg[i-1];
                        q_abs_reg[i]  <= q_abs_reg[i-1];
                    end
                q_task_reg[ipos[IW-1:0]] <= id;
                q_abs_reg[ipos[IW-1:0]]  <= abs_reg;
            end
            if (q_del || q_pop)
            begin
                for (int i = 0; i < N - 1; i++)
                    if (q_pop || IW'(i) >= qpos_reg)
                    begin
                        q_task_reg[i] <= q_task_reg[i+1];
                        q_abs_reg[i]  <= q_abs_reg[i+1];
                    end
            end
        end
    end

    // length fields follow the queue count, already updated by exec
    assign rsp = {status_reg, tout_reg, count_reg != '0, 5'(count_reg)};
endmodule
`default_nettype wire

### design/edq_ctrl.sv
// Controller: sequences load, lookup, exec and output hold.
// Depends on edq_pkg.
`default_nettype none
module edq_ctrl (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           in_valid,
    output logic                in_ready,
    output logic                out_valid,
    input  wire logic           out_ready,
    output edq_pkg::cmd_t       cmd
);
    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_LOOK = 2'd1;
    localparam logic [1:0] S_EXEC = 2'd2;
    localparam logic [1:0] S_OUT  = 2'd3;

    logic [1:0] state_reg, state_next;

    assign in_ready  = state_reg == S_IDLE;
    assign out_valid = state_reg == S_OUT;
    // load, lookup, exec
    assign cmd = {in_ready && in_valid, state_reg == S_LOOK, state_reg == S_EXEC};

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: if (in_valid) state_next = S_LOOK;
            S_LOOK: state_next = S_EXEC;
            S_EXEC: state_next = S_OUT;
            S_OUT:  if (out_ready) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    a_one_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(cmd)) else $error("overlapping commands");
    a_exec_then_out: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.exec |=> out_valid) else $error("no result after exec");
    a_look_after_load: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |=> cmd.lookup) else $error("lookup skipped");
endmodule
`default_nettype wire

### sim/tb_edq_if.sv
// Testbench-side copy is not needed; the design interface edq_if is used as is.
// This file holds the request/response beat helpers type aliases only.
// Depends on edq_pkg.
`timescale 1ns / 100ps
package tb_edq_types;
    typedef edq_pkg::req_t cmd_beat_t;
    typedef edq_pkg::rsp_t reply_beat_t;
endpackage

### sim/tb.sv
// Testbench for edf_deadline_queue_unit: directed and random scheduler ops,
// checked beat by beat against an in-bench EDF queue predictor.
// Depends on edq_pkg, edq_if, tb_edq_types and the RTL.
`timescale 1ns / 100ps
module tb;
    logic clk = 1'b0;
    logic rst_n = 1'b0;
    always #5 clk = ~clk;

    edq_if #(.T(edq_pkg::req_t)) req (clk);
    edq_if #(.T(edq_pkg::rsp_t)) rsp (clk);

    edf_deadline_queue_unit u_top (.clk(clk), .rst_n(rst_n), .req(req), .rsp(rsp));

    // predictor state: registry and sorted ready queue
    logic        sch_reg_used [edq_pkg::CAPACITY];
    logic [15:0] sch_reg_id [edq_pkg::CAPACITY];
    logic [31:0] sch_reg_rel [edq_pkg::CAPACITY];
    logic [15:0] sch_q_id [edq_pkg::CAPACITY];
    logic [31:0] sch_q_abs [edq_pkg::CAPACITY];
    int          sch_q_len;

    tb_edq_types::cmd_beat_t   pending_ops[$];
    tb_edq_types::reply_beat_t expected_replies[$];
    int          err_cnt = 0;
    int          stall_cnt = 0;
    bit          quiet_phase = 1'b0;   // long stretch with no idling

    function automatic bit later_than(logic [31:0] a, logic [31:0] b);
        logic [31:0] d;
        d = a - b;
        return (d != 0) && !d[31];
    endfunction

    function automatic int reg_lookup(logic [15:0] id);
        for (int i = 0; i < edq_pkg::CAPACITY; i++)
            if (sch_reg_used[i] && sch_reg_id[i] == id) return i;
        return -1;
    endfunction

    function automatic int queue_lookup(logic [15:0] id);
        for (int i = 0; i < sch_q_len; i++)
            if (sch_q_id[i] == id) return i;
        return -1;
    endfunction

    function automatic void queue_pop_at(int pos);
        for (int i = pos; i + 1 < sch_q_len; i++)
        begin
            sch_q_id[i]  = sch_q_id[i + 1];
            sch_q_abs[i] = sch_q_abs[i + 1];
        end
        sch_q_len--;
    endfunction

    // apply one op to the predictor, return the reply it should produce
    function automatic tb_edq_types::reply_beat_t schedule_op(tb_edq_types::cmd_beat_t c);
        tb_edq_types::reply_beat_t r;
        int k;
        int pos;
        logic [31:0] abs_dl;
        r = '0;
        r.status = edq_pkg::ST_OK;
        if (c.opcode <= edq_pkg::OP_REMOVE && c.task_id == 0)
            r.status = edq_pkg::ST_BAD_ID;
        else if (c.opcode == edq_pkg::OP_ASSIGN || c.opcode == edq_pkg::OP_UPDATE)
        begin
            k = reg_lookup(c.task_id);
            if (k >= 0)
                sch_reg_rel[k] = c.deadline;
            else if (c.opcode == edq_pkg::OP_UPDATE)
                r.status = edq_pkg::ST_NOT_FOUND;
            else
            begin
                r.status = edq_pkg::ST_FULL;
                for (int i = 0; i < edq_pkg::CAPACITY; i++)
                    if (!sch_reg_used[i])
                    begin
                        sch_reg_used[i] = 1'b1;
                        sch_reg_id[i]   = c.task_id;
                        sch_reg_rel[i]  = c.deadline;
                        r.status = edq_pkg::ST_OK;
                        break;
                    end
            end
        end
        else if (c.opcode == edq_pkg::OP_ADD)
        begin
            k = reg_lookup(c.task_id);
            if (sch_q_len >= edq_pkg::CAPACITY)
                r.status = edq_pkg::ST_FULL;
            else if (queue_lookup(c.task_id) >= 0)
                r.status = edq_pkg::ST_QUEUED;
            else if (k < 0)
                r.status = edq_pkg::ST_NOT_FOUND;
            else
            begin
                abs_dl = c.cur_tick + sch_reg_rel[k];
                pos = sch_q_len;
                for (int i = 0; i < sch_q_len; i++)
                    if (later_than(sch_q_abs[i], abs_dl))
                    begin
                        pos = i;
                        break;
                    end
                for (int i = sch_q_len; i > pos; i--)
                begin
                    sch_q_id[i]  = sch_q_id[i - 1];
                    sch_q_abs[i] = sch_q_abs[i - 1];
                end
                sch_q_id[pos]  = c.task_id;
                sch_q_abs[pos] = abs_dl;
                sch_q_len++;
            end
        end
        else if (c.opcode == edq_pkg::OP_REMOVE)
        begin
            k = queue_lookup(c.task_id);
            if (k < 0) r.status = edq_pkg::ST_NOT_FOUND;
            else queue_pop_at(k);
        end
        else if (c.opcode == edq_pkg::OP_PEEK || c.opcode == edq_pkg::OP_SELECT)
        begin
            if (sch_q_len == 0)
                r.status = edq_pkg::ST_NOT_FOUND;
            else
            begin
                r.task_out = sch_q_id[0];
                if (c.opcode == edq_pkg::OP_SELECT) queue_pop_at(0);
            end
        end
        else if (c.opcode == edq_pkg::OP_CLEAR)
            sch_q_len = 0;
        r.ready_res = (sch_q_len > 0);
        r.queue_len = sch_q_len[4:0];
        return r;
    endfunction

    function automatic tb_edq_types::cmd_beat_t mk_op(logic [2:0] op, logic [15:0] id,
                                                      logic [31:0] dl, logic [31:0] tick);
        tb_edq_types::cmd_beat_t c;
        c.opcode = op;
        c.task_id = id;
        c.deadline = dl;
        c.cur_tick = tick;
        return c;
    endfunction

    // random id mostly from small pools so registry, duplicates and full hit often
    function automatic logic [15:0] pick_id();
        int sel;
        sel = $urandom_range(0, 99);
        if (sel < 4) return 16'd0;
        if (sel < 40) return 16'($urandom_range(1, 20));
        if (sel < 80) return 16'($urandom_range(101, 118));
        return 16'($urandom);
    endfunction

    function automatic logic [31:0] pick_word();
        case ($urandom_range(0, 4))
            0: return 32'h0;
            1: return 32'hFFFF_FFFF;
            2: return 32'($urandom_range(0, 200));
            3: return 32'h8000_0000 + 32'($urandom_range(0, 3)) - 32'd2;
            default: return $urandom;
        endcase
    endfunction

    // stimulus
    initial
    begin
        logic [2:0] op;
        int w;
        // directed: bad ids, empty queue ops, extreme fields
        pending_ops.push_back(mk_op(edq_pkg::OP_ASSIGN, 16'd0, 32'd5, 32'd0));
        pending_ops.push_back(mk_op(edq_pkg::OP_UPDATE, 16'd0, 32'd5, 32'd0));
        pending_ops.push_back(mk_op(edq_pkg::OP_ADD, 16'd0, 32'd0, 32'd0));
        pending_ops.push_back(mk_op(edq_pkg::OP_REMOVE, 16'd0, 32'd0, 32'd0));
        pending_ops.push_back(mk_op(edq_pkg::OP_PEEK, 16'hFFFF, 32'd0, 32'd0));
        pending_ops.push_back(mk_op(edq_pkg::OP_SELECT, 16'd0, 32'd0, 32'd0));
        pending_ops.push_back(mk_op(edq_pkg::OP_UPDATE, 16'd3, 32'd9, 32'd0));
        pending_ops.push_back(mk_op(edq_pkg::OP_ADD, 16'd3, 32'd0, 32'd0));
        pending_ops.push_back(mk_op(edq_pkg::OP_ASSIGN, 16'hFFFF, 32'hFFFF_FFFF, 32'd0));
        pending_ops.push_back(mk_op(edq_pkg::OP_ASSIGN, 16'd1, 32'd10, 32'd0));
        pending_ops.push_back(mk_op(edq_pkg::OP_ASSIGN, 16'd2, 32'd10, 32'd0));
        pending_ops.push_back(mk_op(edq_pkg::OP_UPDATE, 16'd2, 32'h7FFF_FFFF, 32'd0));
        // wrap: later deadline crosses 2^32
        pending_ops.push_back(mk_op(edq_pkg::OP_ADD, 16'hFFFF, 32'd0, 32'hFFFF_FFFF));
        pending_ops.push_back(mk_op(edq_pkg::OP_ADD, 16'd1, 32'd0, 32'hFFFF_FFF0));
        pending_ops.push_back(mk_op(edq_pkg::OP_ADD, 16'd1, 32'd0, 32'd0));
        pending_ops.push_back(mk_op(edq_pkg::OP_UPDATE, 16'd2, 32'd10, 32'd0));
        pending_ops.push_back(mk_op(edq_pkg::OP_ADD, 16'd2, 32'd0, 32'hFFFF_FFF0)); // tie, FIFO
        pending_ops.push_back(mk_op(edq_pkg::OP_PEEK, 16'd0, 32'd0, 32'd0));
        pending_ops.push_back(mk_op(edq_pkg::OP_REMOVE, 16'd9, 32'd0, 32'd0));
        pending_ops.push_back(mk_op(edq_pkg::OP_REMOVE, 16'd2, 32'd0, 32'd0));
        pending_ops.push_back(mk_op(edq_pkg::OP_SELECT, 16'd0, 32'd0, 32'd0));
        pending_ops.push_back(mk_op(edq_pkg::OP_CLEAR, 16'd0, 32'd0, 32'd0));
        pending_ops.push_back(mk_op(edq_pkg::OP_NOP, 16'd5, 32'd5, 32'd5));
        // fill registry beyond capacity to reach full
        for (int i = 1; i <= edq_pkg::CAPACITY + 2; i++)
            pending_ops.push_back(mk_op(edq_pkg::OP_ASSIGN, 16'(100 + i), 32'(i), 32'd0));
        for (int i = 1; i <= edq_pkg::CAPACITY + 1; i++)
            pending_ops.push_back(mk_op(edq_pkg::OP_ADD, 16'(100 + (i % 14) + 1), 32'd0,
                                        32'(i)));
        pending_ops.push_back(mk_op(edq_pkg::OP_CLEAR, 16'd0, 32'd0, 32'd0));
        // random part: weighted mix of all opcodes, with noisy ids and fields
        for (int n = 0; n < 1000; n++)
        begin
            w = $urandom_range(0, 99);
            if (w < 12) op = edq_pkg::OP_ASSIGN;
            else if (w < 20) op = edq_pkg::OP_UPDATE;
            else if (w < 55) op = edq_pkg::OP_ADD;
            else if (w < 63) op = edq_pkg::OP_REMOVE;
            else if (w < 71) op = edq_pkg::OP_PEEK;
            else if (w < 93) op = edq_pkg::OP_SELECT;
            else if (w < 97) op = edq_pkg::OP_CLEAR;
            else op = edq_pkg::OP_NOP;
            pending_ops.push_back(mk_op(op, pick_id(), pick_word(), pick_word()));
        end
    end

    // driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req.valid <= 1'b0;
            req.data  <= '0;
        end
        else if (!req.valid || req.ready)
        begin
            if (pending_ops.size() > 0 && (quiet_phase || $urandom_range(0, 99) >= 26))
            begin
                req.valid <= 1'b1;
                req.data  <= pending_ops.pop_front();
            end
            else
                req.valid <= 1'b0;
        end
    end

    // accepted beat feeds the predictor
    always @(posedge clk)
        if (rst_n && req.valid && req.ready)
            expected_replies.push_back(schedule_op(req.data));

    // sink-side backpressure
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rsp.ready <= 1'b0;
        else
            rsp.ready <= quiet_phase || ($urandom_range(0, 99) >= 26);
    end

    // monitor
    always @(posedge clk)
    begin
        tb_edq_types::reply_beat_t exp_r;
        if (rst_n && rsp.valid && rsp.ready)
        begin
            if (expected_replies.size() == 0)
            begin
                $display("%0t: unexpected reply, actual %p", $time, rsp.data);
                err_cnt++;
            end
            else
            begin
                exp_r = expected_replies.pop_front();
                if (rsp.data.status !== exp_r.status)
                begin
                    $display("%0t: status exp %0d act %0d", $time, exp_r.status,
                             rsp.data.status);
                    err_cnt++;
                end
                if (rsp.data.task_out !== exp_r.task_out)
                begin
                    $display("%0t: task_out exp %0d act %0d", $time, exp_r.task_out,
                             rsp.data.task_out);
                    err_cnt++;
                end
                if (rsp.data.ready_res !== exp_r.ready_res)
                begin
                    $display("%0t: ready_res exp %0d act %0d", $time, exp_r.ready_res,
                             rsp.data.ready_res);
                    err_cnt++;
                end
                if (rsp.data.queue_len !== exp_r.queue_len)
                begin
                    $display("%0t: queue_len exp %0d act %0d", $time, exp_r.queue_len,
                             rsp.data.queue_len);
                    err_cnt++;
                end
            end
        end
    end

    // watchdog: cycles with no beat on either side
    always @(posedge clk)
    begin
        if ((req.valid && req.ready) || (rsp.valid && rsp.ready))
            stall_cnt <= 0;
        else
            stall_cnt <= stall_cnt + 1;
        if (stall_cnt > 2000)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    initial
    begin
        for (int i = 0; i < edq_pkg::CAPACITY; i++)
            sch_reg_used[i] = 1'b0;
        sch_q_len = 0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        repeat (300) @(posedge clk);
        quiet_phase <= 1'b1;
        repeat (400) @(posedge clk);
        quiet_phase <= 1'b0;
        wait (pending_ops.size() == 0 && !req.valid && expected_replies.size() == 0);
        repeat (20) @(posedge clk);
        if (err_cnt == 0 && expected_replies.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end
endmodule

### edf_deadline_queue_unit.f
design/edq_pkg.sv
design/edq_if.sv
design/edq_datapath.sv
design/edq_ctrl.sv
design/edf_deadline_queue_unit.sv
sim/tb_edq_if.sv
sim/tb.sv
